FILE: rtl/ilbd_pkg.sv
`default_nettype none

package ilbd_pkg;

  // Configuration port geometry
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 5;

  // Scale factor is an unsigned Q16.16 value
  localparam int unsigned SCALE_FRAC = 16;

  // Entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Item function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_SEGMENT = 1'b1;

  typedef enum logic [2:0] {
    REG_MAX_BITS    = 3'd0,
    REG_LOW_BOUND   = 3'd1,
    REG_HIGH_BOUND  = 3'd2,
    REG_SCALE       = 3'd3,
    REG_SYMBOL_MODE = 3'd4
  } ilbd_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MULH,
    ST_MULL,
    ST_FIN
  } ilbd_state_e;

  typedef struct packed {
    logic [3:0]         max_bits;
    logic signed [15:0] low_bound;
    logic signed [15:0] high_bound;
    logic [31:0]        scale;
    logic               symbol_mode;
  } ilbd_cfg_t;

  // One classified segment: distance magnitude to its region
  typedef struct packed {
    logic        last;
    logic        big;
    logic [31:0] mag;
  } ilbd_seg_t;

endpackage

`default_nettype wire

FILE: rtl/ilbd_front.sv
`default_nettype none

module ilbd_front import ilbd_pkg::*; #(
  parameter int unsigned SYMBOL_WIDTH = 8,
  parameter int unsigned TABLE_DEPTH  = 255,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ilbd_cfg_t          cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic [7:0]         table_index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [7:0]         symbol_i,
  input  wire logic [3:0]         symbol_bits_i,
  input  wire logic               last_i,
  output logic                    push_o,
  output ilbd_seg_t               push_data_o,
  input  wire logic               full_i
);

  localparam int unsigned SW        = SYMBOL_WIDTH;
  localparam int unsigned MW        = $clog2(SW + 1);
  localparam int unsigned AW        = $clog2(TABLE_DEPTH);
  localparam int unsigned SYM_EXT_W = SW + 8;
  localparam int unsigned BND_W     = (FRAC_BITS + 16 > 32) ? FRAC_BITS + 16 : 32;
  localparam int unsigned DW        = BND_W + 1;
  localparam logic [16:0] DEPTH_L   = 17'(TABLE_DEPTH);
  localparam logic [4:0]  SW_L      = 5'(SW);

  logic              accept, seg_acc, load_acc;
  logic [4:0]        mb5, m5, c5, s5;
  logic [MW-1:0]     m, s;
  logic [SYM_EXT_W-1:0] sym_ext;
  logic [SW-1:0]     v, top, low_mask, rlo, rhi, lo_addr;
  logic [16:0]       lo_ext, hi_ext, ld_ext;
  logic              ld_ok;

  logic [31:0]       mem_q [TABLE_DEPTH];
  logic [31:0]       rd_lo_q, rd_hi_q;
  logic              lo_edge_q, hi_edge_q, lo_oor_q, hi_oor_q, last_q;
  logic signed [31:0] paa_q;
  logic              st_vld_q, st_vld_d;

  logic signed [DW-1:0] paa, blo, bhi, lo_b, hi_b, d_lo, d_hi;
  logic              lo_viol, hi_viol;
  logic [DW-1:0]     mag;

  assign in_stall_o = st_vld_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign seg_acc    = accept && (func_i == FUNC_SEGMENT);
  assign load_acc   = accept && (func_i == FUNC_LOAD);

  // Region of maximum-cardinality symbols covered by this symbol
  always_comb begin
    mb5 = {1'b0, cfg_i.max_bits};
    if (mb5 == 5'd0) begin
      m5 = 5'd1;
    end else if (mb5 > SW_L) begin
      m5 = SW_L;
    end else begin
      m5 = mb5;
    end
    c5 = {1'b0, symbol_bits_i};
    if (c5 > m5) begin
      c5 = m5;
    end
    s5 = m5 - c5;
    m  = m5[MW-1:0];
    s  = s5[MW-1:0];

    sym_ext  = SYM_EXT_W'(symbol_i);
    v        = sym_ext[SW-1:0];
    top      = ~({SW{1'b1}} << m);
    low_mask = ~({SW{1'b1}} << s);
    if (cfg_i.symbol_mode) begin
      rlo = (v << s) & top;
    end else begin
      rlo = v & top & ~low_mask;
    end
    rhi     = rlo | low_mask;
    lo_addr = rlo - 1'b1;
    lo_ext  = 17'(lo_addr);
    hi_ext  = 17'(rhi);
  end

  assign ld_ext = 17'(table_index_i);
  assign ld_ok  = ld_ext < DEPTH_L;

  always_ff @(posedge clk_i) begin
    if (load_acc && ld_ok) begin
      mem_q[ld_ext[AW-1:0]] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_acc) begin
      rd_lo_q   <= mem_q[lo_ext[AW-1:0]];
      rd_hi_q   <= mem_q[hi_ext[AW-1:0]];
      lo_edge_q <= (rlo == '0);
      hi_edge_q <= (rhi == top);
      lo_oor_q  <= !(lo_ext < DEPTH_L);
      hi_oor_q  <= !(hi_ext < DEPTH_L);
      paa_q     <= value_i;
      last_q    <= last_i;
    end
  end

  assign push_o = st_vld_q && !full_i;

  always_comb begin
    st_vld_d = st_vld_q;
    if (seg_acc) begin
      st_vld_d = 1'b1;
    end else if (push_o) begin
      st_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= st_vld_d;
    end
  end

  // Bounds at the outer edges come from the configured integers
  always_comb begin
    paa  = DW'(paa_q);
    lo_b = DW'(cfg_i.low_bound) <<< FRAC_BITS;
    hi_b = DW'(cfg_i.high_bound) <<< FRAC_BITS;
    if (lo_edge_q) begin
      blo = lo_b;
    end else if (lo_oor_q) begin
      blo = '0;
    end else begin
      blo = DW'(signed'(rd_lo_q));
    end
    if (hi_edge_q) begin
      bhi = hi_b;
    end else if (hi_oor_q) begin
      bhi = '0;
    end else begin
      bhi = DW'(signed'(rd_hi_q));
    end
    d_lo    = blo - paa;
    d_hi    = paa - bhi;
    lo_viol = blo > paa;
    hi_viol = bhi < paa;
    if (lo_viol) begin
      mag = d_lo;
    end else if (hi_viol) begin
      mag = d_hi;
    end else begin
      mag = '0;
    end
    push_data_o.last = last_q;
    push_data_o.big  = |mag[DW-1:32];
    push_data_o.mag  = mag[31:0];
  end

endmodule

`default_nettype wire

FILE: rtl/ilbd_fifo.sv
`default_nettype none

module ilbd_fifo import ilbd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire ilbd_seg_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output ilbd_seg_t      data_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  ilbd_seg_t        entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/ilbd_back.sv
`default_nettype none

module ilbd_back import ilbd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] scale_i,
  output logic             pop_o,
  input  wire ilbd_seg_t   pop_data_i,
  input  wire logic        empty_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      distance_o,
  output logic             overflow_o
);

  ilbd_state_e state_q, state_d;

  logic [63:0] sum_q, sum_d;
  logic        sat_q, sat_d;
  logic [63:0] prod_q, hi_q;
  logic        big_q, last_q;
  logic        out_vld_q, out_vld_d;
  logic [63:0] dist_q;
  logic        ovf_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        prod_en, hi_en, acc_en, out_load, out_free;

  logic        acc_c, fin_c, hi_ovf, fin_ovf;
  logic [63:0] acc_s, fin_a, fin_b, fin_s;

  assign out_free = !out_vld_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = last_q ? ST_MULH : ST_IDLE;
      end
      ST_MULH: state_d = ST_MULL;
      ST_MULL: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: one shared multiplier
  always_comb begin
    pop_o    = 1'b0;
    prod_en  = 1'b0;
    hi_en    = 1'b0;
    acc_en   = 1'b0;
    out_load = 1'b0;
    mul_a    = pop_data_i.mag;
    mul_b    = pop_data_i.mag;
    case (state_q)
      ST_IDLE: begin
        pop_o   = !empty_i;
        prod_en = !empty_i;
      end
      ST_ACC: acc_en = 1'b1;
      ST_MULH: begin
        mul_a   = sum_q[63:32];
        mul_b   = scale_i;
        prod_en = 1'b1;
      end
      ST_MULL: begin
        mul_a   = sum_q[31:0];
        mul_b   = scale_i;
        prod_en = 1'b1;
        hi_en   = 1'b1;
      end
      ST_FIN: out_load = out_free;
      default: ;
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Accumulate with saturation, and clear when a result is loaded
  always_comb begin
    {acc_c, acc_s} = {1'b0, sum_q} + {1'b0, prod_q};
    sum_d = sum_q;
    sat_d = sat_q;
    if (acc_en) begin
      if (big_q || acc_c) begin
        sum_d = '1;
        sat_d = 1'b1;
      end else begin
        sum_d = acc_s;
      end
    end else if (out_load) begin
      sum_d = '0;
      sat_d = 1'b0;
    end
  end

  // Recombine the two partial products of sum times scale
  always_comb begin
    hi_ovf        = |hi_q[63:64-SCALE_FRAC];
    fin_a         = hi_q << SCALE_FRAC;
    fin_b         = prod_q >> SCALE_FRAC;
    {fin_c, fin_s} = {1'b0, fin_a} + {1'b0, fin_b};
    fin_ovf       = sat_q || hi_ovf || fin_c;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sum_q     <= '0;
      sat_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      sat_q     <= sat_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en) begin
      prod_q <= mul_p;
    end
    if (hi_en) begin
      hi_q <= prod_q;
    end
    if (pop_o) begin
      big_q  <= pop_data_i.big;
      last_q <= pop_data_i.last;
    end
    if (out_load) begin
      dist_q <= fin_ovf ? '1 : fin_s;
      ovf_q  <= fin_ovf;
    end
  end

  assign out_valid_o = out_vld_q;
  assign distance_o  = dist_q;
  assign overflow_o  = ovf_q;

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (sum_q == '0 && !sat_q))
    else $error("accumulator not cleared after result");

  a_big_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && big_q) |=> (sat_q && sum_q == '1))
    else $error("oversized distance did not saturate");

endmodule

`default_nettype wire

FILE: rtl/isax_lower_bound_distance.sv
// A last segment passes the front stage register, the queue and the back-end states
// IDLE, ACC, MULH, MULL and FIN to give its distance word. The input takes one word
// per cycle unless in_stall_o holds it; the back end squares segments and scales the
// sum on one shared multiplier. Loads produce no word. Reset is asynchronous, active
// low: it restores the register defaults, empties the queue and clears the sum; the
// breakpoint table is not cleared and must be loaded before use.
`default_nettype none

module isax_lower_bound_distance import ilbd_pkg::*; #(
  parameter int unsigned SYMBOL_WIDTH = 8,
  parameter int unsigned TABLE_DEPTH  = 255,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                func_i,
  input  wire logic [7:0]          table_index_i,
  input  wire logic signed [31:0]  value_i,
  input  wire logic [7:0]          symbol_i,
  input  wire logic [3:0]          symbol_bits_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [63:0]              distance_o,
  output logic                     overflow_o
);

  ilbd_cfg_t cfg_q, cfg_d;
  ilbd_reg_e reg_sel;
  logic      cfg_wr;

  logic      push, full, pop, empty;
  ilbd_seg_t push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_sel = ilbd_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_MAX_BITS:    cfg_d.max_bits    = pwdata[3:0];
        REG_LOW_BOUND:   cfg_d.low_bound   = pwdata[15:0];
        REG_HIGH_BOUND:  cfg_d.high_bound  = pwdata[15:0];
        REG_SCALE:       cfg_d.scale       = pwdata[31:0];
        REG_SYMBOL_MODE: cfg_d.symbol_mode = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAX_BITS:    prdata = {28'd0, cfg_q.max_bits};
      REG_LOW_BOUND:   prdata = {16'd0, cfg_q.low_bound};
      REG_HIGH_BOUND:  prdata = {16'd0, cfg_q.high_bound};
      REG_SCALE:       prdata = cfg_q.scale;
      REG_SYMBOL_MODE: prdata = {31'd0, cfg_q.symbol_mode};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_bits    <= 4'd8;
      cfg_q.low_bound   <= 16'sh8000;
      cfg_q.high_bound  <= 16'sh7FFF;
      cfg_q.scale       <= 32'h0001_0000;
      cfg_q.symbol_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ilbd_front #(
    .SYMBOL_WIDTH(SYMBOL_WIDTH),
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .table_index_i(table_index_i),
    .value_i      (value_i),
    .symbol_i     (symbol_i),
    .symbol_bits_i(symbol_bits_i),
    .last_i       (last_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  ilbd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .data_o (pop_data),
    .empty_o(empty)
  );

  ilbd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scale_i    (cfg_q.scale),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .distance_o (distance_o),
    .overflow_o (overflow_o)
  );

endmodule

`default_nettype wire

FILE: tb/isax_lower_bound_distance_tb.sv
`timescale 1ns / 1ps

module isax_lower_bound_distance_tb;
  import ilbd_pkg::*;

  localparam int unsigned NUM_BP       = 255;
  localparam int unsigned SYM_W        = 8;
  localparam longint      ONE_Q        = 64'sd65536;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic        func;
    logic [7:0]  idx;
    logic [31:0] value;
    logic [7:0]  sym;
    logic [3:0]  sbits;
    logic        last;
  } isax_word_t;

  typedef struct packed {
    logic [63:0] distance;
    logic        overflow;
  } dist_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                func_i        = FUNC_LOAD;
  logic [7:0]          table_index_i = '0;
  logic signed [31:0]  value_i       = '0;
  logic [7:0]          symbol_i      = '0;
  logic [3:0]          symbol_bits_i = '0;
  logic                last_i        = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [63:0]         distance_o;
  logic                overflow_o;

  // Predictor state and its copy of the registers
  logic [31:0]        bp_table [NUM_BP] = '{default: '0};
  logic [63:0]        sum_acc         = '0;
  logic               sum_sat         = 1'b0;
  logic [3:0]         cfg_max_bits    = 4'd8;
  logic signed [15:0] cfg_low         = 16'sh8000;
  logic signed [15:0] cfg_high        = 16'sh7FFF;
  logic [31:0]        cfg_scale       = 32'd65536;
  logic               cfg_symbol_mode = 1'b0;

  isax_word_t pending_q [$];
  dist_word_t dist_expect_q [$];
  isax_word_t cur_word;
  dist_word_t got_exp;

  int          err_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int          gap_left   = 0;
  int          burst_left = 0;
  int          hold_req   = 0;
  int          hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  logic [1:0]  rx_mode    = 2'd0;

  isax_lower_bound_distance DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .table_index_i (table_index_i),
    .value_i       (value_i),
    .symbol_i      (symbol_i),
    .symbol_bits_i (symbol_bits_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .distance_o    (distance_o),
    .overflow_o    (overflow_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned eff_max_bits();
    if (cfg_max_bits < 1) return 1;
    if (cfg_max_bits > SYM_W) return SYM_W;
    return cfg_max_bits;
  endfunction

  function automatic longint bp_lookup(input int unsigned idx);
    if (idx >= NUM_BP) return 0;
    return longint'($signed(bp_table[idx]));
  endfunction

  function automatic void add_square(input logic [63:0] mag);
    logic [63:0] sq;
    logic [64:0] total;
    if (mag > 64'hFFFF_FFFF) begin
      sum_sat = 1'b1;
      sum_acc = '1;
      return;
    end
    sq    = mag * mag;
    total = {1'b0, sum_acc} + {1'b0, sq};
    if (total[64]) begin
      sum_sat = 1'b1;
      sum_acc = '1;
    end else begin
      sum_acc = total[63:0];
    end
  endfunction

  // Advance the distance model by one accepted word
  function automatic void apply_word(input isax_word_t w);
    int unsigned m, c, s, region_top, v, rlo, rhi;
    longint      paa, blo, bhi;
    logic [63:0] hi_p, lo_p, a_p, b_p;
    logic [64:0] tot;
    dist_word_t  e;
    if (w.func == FUNC_LOAD) begin
      if (w.idx < NUM_BP) bp_table[w.idx] = w.value;
      return;
    end
    m          = eff_max_bits();
    c          = (w.sbits > m) ? m : w.sbits;
    s          = m - c;
    region_top = (32'd1 << m) - 1;
    v          = w.sym;
    if (cfg_symbol_mode == 1'b0) rlo = ((v & region_top) >> s) << s;
    else rlo = (v << s) & region_top;
    rhi = rlo | ((32'd1 << s) - 1);
    paa = longint'($signed(w.value));
    blo = (rlo == 0) ? longint'(cfg_low) * ONE_Q : bp_lookup(rlo - 1);
    bhi = (rhi == region_top) ? longint'(cfg_high) * ONE_Q : bp_lookup(rhi);
    // lower bound wins when both are violated
    if (blo > paa) add_square(64'(blo - paa));
    else if (bhi < paa) add_square(64'(paa - bhi));
    if (!w.last) return;
    e.overflow = sum_sat;
    if (sum_sat) begin
      e.distance = '1;
    end else begin
      hi_p = {32'd0, sum_acc[63:32]} * {32'd0, cfg_scale};
      lo_p = {32'd0, sum_acc[31:0]} * {32'd0, cfg_scale};
      a_p  = hi_p << SCALE_FRAC;
      b_p  = lo_p >> SCALE_FRAC;
      tot  = {1'b0, a_p} + {1'b0, b_p};
      if (hi_p >= (64'd1 << (64 - SCALE_FRAC)) || tot[64]) begin
        e.overflow = 1'b1;
        e.distance = '1;
      end else begin
        e.distance = tot[63:0];
      end
    end
    dist_expect_q.push_back(e);
    sum_acc = '0;
    sum_sat = 1'b0;
  endfunction

  // Driver: bursts of words with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) apply_word(cur_word);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_word      = pending_q.pop_front();
          in_valid_i    <= 1'b1;
          func_i        <= cur_word.func;
          table_index_i <= cur_word.idx;
          value_i       <= cur_word.value;
          symbol_i      <= cur_word.sym;
          symbol_bits_i <= cur_word.sbits;
          last_i        <= cur_word.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= 2'($urandom_range(0, 3));
        mode_left <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        2'd0: out_stall_i <= 1'b0;
        2'd1: out_stall_i <= 1'($urandom_range(0, 1));
        2'd2: out_stall_i <= (cycle_cnt % 4) != 0;
        default: out_stall_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Monitor: check each distance word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dist_expect_q.size() == 0) begin
        $error("unexpected distance word: distance %h overflow %b", distance_o, overflow_o);
        err_cnt++;
      end else begin
        got_exp = dist_expect_q.pop_front();
        if (distance_o !== got_exp.distance) begin
          $error("distance: expected %h, actual %h", got_exp.distance, distance_o);
          err_cnt++;
        end
        if (overflow_o !== got_exp.overflow) begin
          $error("overflow: expected %b, actual %b", got_exp.overflow, overflow_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic apb_write(input ilbd_reg_e r, input logic [31:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] mb, input logic signed [15:0] lo,
                            input logic signed [15:0] hi, input logic [31:0] sc,
                            input logic md);
    apb_write(REG_MAX_BITS, {28'd0, mb});
    apb_write(REG_LOW_BOUND, {{16{lo[15]}}, lo});
    apb_write(REG_HIGH_BOUND, {{16{hi[15]}}, hi});
    apb_write(REG_SCALE, sc);
    apb_write(REG_SYMBOL_MODE, {31'd0, md});
    cfg_max_bits    = mb;
    cfg_low         = lo;
    cfg_high        = hi;
    cfg_scale       = sc;
    cfg_symbol_mode = md;
  endtask

  // Hold until every word is in and every distance is out, then drain
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || dist_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_load(input logic [7:0] idx, input logic [31:0] val);
    isax_word_t w;
    w       = '0;
    w.func  = FUNC_LOAD;
    w.idx   = idx;
    w.value = val;
    w.sym   = 8'($urandom());
    w.sbits = 4'($urandom_range(0, SYM_W));
    w.last  = 1'($urandom_range(0, 1));
    pending_q.push_back(w);
  endtask

  task automatic push_seg(input logic [31:0] val, input logic [7:0] sym,
                          input logic [3:0] sbits, input logic lst);
    isax_word_t w;
    w.func  = FUNC_SEGMENT;
    w.idx   = 8'($urandom());
    w.value = val;
    w.sym   = sym;
    w.sbits = sbits;
    w.last  = lst;
    pending_q.push_back(w);
  endtask

  function automatic logic [31:0] gen_paa();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    if (r < 8) return bp_table[$urandom_range(0, NUM_BP - 1)] + 32'($urandom_range(0, 64)) - 32;
    return $urandom();
  endfunction

  task automatic push_query(input int n_seg, input bit noisy);
    int unsigned m, c;
    logic [7:0]  sym;
    m = eff_max_bits();
    for (int i = 0; i < n_seg; i++) begin
      c = noisy ? $urandom_range(0, SYM_W) : $urandom_range(0, m);
      if (noisy || cfg_symbol_mode == 1'b0) sym = 8'($urandom());
      else sym = 8'($urandom_range(0, (1 << c) - 1));
      push_seg(gen_paa(), sym, 4'(c), i == n_seg - 1);
      // drop a table load into the middle of a broken query now and then
      if (noisy && i != n_seg - 1 && $urandom_range(0, 3) == 0)
        push_load(8'($urandom_range(0, NUM_BP - 1)), $urandom());
    end
  endtask

  task automatic push_traffic(input int n_items);
    int          cnt, n_seg, r;
    int unsigned li;
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        push_load(8'd255, $urandom());
      end else if (r < 12) begin
        li = $urandom_range(0, NUM_BP - 1);
        push_load(8'(li), ($urandom_range(0, 1) == 1) ? $urandom()
                                                      : bp_table[li] + 32'($urandom_range(0, 255)));
        cnt++;
      end else begin
        n_seg = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
        push_query(n_seg, r >= 88);
        cnt += n_seg;
      end
    end
  endtask

  initial begin
    int                 bp_val;
    logic [3:0]         r_mb;
    logic signed [15:0] r_lo, r_hi;
    logic [31:0]        r_sc;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(4'd8, 16'sh8000, 16'sh7FFF, 32'd65536, 1'b0);
    // ascending breakpoints over roughly -3.0 .. +5.0
    bp_val = -(3 << 16);
    for (int i = 0; i < NUM_BP; i++) begin
      bp_val += $urandom_range(1500, 2600);
      push_load(8'(i), 32'(bp_val));
    end
    push_load(8'd255, 32'hDEAD_BEEF);
    push_seg(32'h8000_0000, 8'h00, 4'd8, 1'b0);
    push_seg(32'h7FFF_FFFF, 8'hFF, 4'd8, 1'b0);
    push_seg(32'h0000_0000, 8'h5A, 4'd0, 1'b1);
    push_seg(-(5 << 16), 8'h80, 4'd1, 1'b0);
    push_seg(5 << 16, 8'h7F, 4'd1, 1'b1);
    push_seg(32'h0000_0000, 8'h3C, 4'd4, 1'b0);
    push_load(8'd0, 32'hFFF0_0000);
    push_seg(32'hFFF8_0000, 8'h00, 4'd8, 1'b1);
    push_load(8'd254, 32'h7FFF_FFFF);
    push_seg(32'h7FFF_0000, 8'hFE, 4'd8, 1'b1);
    push_seg(32'h0003_0000, 8'hC3, 4'd7, 1'b1);
    push_traffic(60);
    wait_idle();

    // reduced symbols, shifted up
    set_config(4'd8, -16'sd4, 16'sd4, 32'd65536, 1'b1);
    push_seg(32'h0000_0000, 8'h01, 4'd1, 1'b0);
    push_seg(32'h0010_0000, 8'h0F, 4'd4, 1'b0);
    push_seg(32'hFFF0_0000, 8'hFF, 4'd2, 1'b1);
    push_traffic(60);
    wait_idle();

    // full scale: scaling overflow without accumulator saturation
    set_config(4'd1, 16'sh8000, 16'sh0000, 32'hFFFF_FFFF, 1'b0);
    push_seg(32'h4000_0000, 8'h01, 4'd1, 1'b0);
    push_seg(32'h4000_0000, 8'h01, 4'd1, 1'b1);
    push_traffic(40);
    wait_idle();

    // crossed bounds: lower-bound violations that saturate the accumulator
    set_config(4'd8, 16'sh7FFF, 16'sh8000, 32'd65536, 1'b0);
    push_seg(32'h8000_0000, 8'h00, 4'd0, 1'b0);
    push_seg(32'h8000_0000, 8'h00, 4'd0, 1'b1);
    push_seg(32'h7FFF_FFFF, 8'hFF, 4'd8, 1'b1);
    push_traffic(40);
    wait_idle();

    set_config(4'd0, -16'sd1, 16'sd1, 32'd1000, 1'b0);
    push_traffic(40);
    wait_idle();

    set_config(4'd15, 16'sh8000, 16'sh8000, 32'd196608, 1'b1);
    push_traffic(40);
    wait_idle();

    set_config(4'd4, 16'sd0, 16'sd0, 32'd0, 1'b1);
    push_traffic(40);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      r_mb = 4'($urandom_range(1, SYM_W));
      r_lo = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'(-int'($urandom_range(0, 6)));
      r_hi = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6));
      case ($urandom_range(0, 3))
        0: r_sc = 32'd65536;
        1: r_sc = $urandom();
        2: r_sc = $urandom_range(0, 65536);
        default: r_sc = 32'hFFFF_FFFF;
      endcase
      set_config(r_mb, r_lo, r_hi, r_sc, 1'($urandom_range(0, 1)));
      // back up the output so the input stalls
      if (p == 2) hold_req++;
      push_traffic(35);
      wait_idle();
    end

    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
